>>> design/lbsos_pkg.sv
`default_nettype none

package lbsos_pkg;

    localparam int NUM_LEDS = 2;

    localparam int IDX_W      = 2;
    localparam int MODE_W     = 3;
    localparam int MS_W       = 16;
    localparam int STEP_W     = 5;
    localparam int CH_W       = 8;
    localparam int COLOUR_W   = 3 * CH_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SOS  = 3'd4;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_IDX = 1'b1;

    localparam logic [STEP_W-1:0] SOS_STEPS      = 5'd19;
    localparam logic [STEP_W-1:0] SOS_WORD_STEP  = 5'd18;
    localparam logic [STEP_W-1:0] SOS_DASH_FIRST = 5'd6;
    localparam logic [STEP_W-1:0] SOS_DASH_LAST  = 5'd10;

    localparam logic [MS_W-1:0] ELAPSED_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_SLOW       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOT        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DASH       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYM_GAP    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR     = 8'd7;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  led_index;
        logic [MODE_W-1:0] new_mode;
    } in_item_t;

    typedef struct packed {
        logic            plain_lit;
        logic            colour_lit;
        logic [CH_W-1:0] drive_red;
        logic [CH_W-1:0] drive_green;
        logic [CH_W-1:0] drive_blue;
        logic            status;
    } out_item_t;

    typedef struct packed {
        logic [MS_W-1:0]     slow_interval_ms;
        logic [MS_W-1:0]     fast_interval_ms;
        logic [MS_W-1:0]     dot_ms;
        logic [MS_W-1:0]     dash_ms;
        logic [MS_W-1:0]     symbol_gap_ms;
        logic [MS_W-1:0]     word_gap_ms;
        logic [CH_W-1:0]     brightness;
        logic [COLOUR_W-1:0] base_colour;
    } cfg_t;

    typedef struct packed {
        logic              tick;
        logic              set;
        logic [MODE_W-1:0] mode;
    } led_cmd_t;

    function automatic logic [MS_W-1:0] sos_duration(input logic [STEP_W-1:0] step,
                                                     input cfg_t cfg);
        logic [MS_W-1:0] dur;
        if (step == SOS_WORD_STEP) begin
            dur = cfg.word_gap_ms;
        end else if (step[0]) begin
            dur = cfg.symbol_gap_ms;
        end else if (step >= SOS_DASH_FIRST && step <= SOS_DASH_LAST) begin
            dur = cfg.dash_ms;
        end else begin
            dur = cfg.dot_ms;
        end
        return dur;
    endfunction

endpackage

`default_nettype wire

>>> design/lbsos_led_unit.sv
`default_nettype none

module lbsos_led_unit (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  lbsos_pkg::led_cmd_t   cmd,
    input  lbsos_pkg::cfg_t       cfg,
    output logic                  lit_next
);

    logic [lbsos_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic                         lit_reg;
    logic [lbsos_pkg::MS_W-1:0]   elapsed_reg, elapsed_next;
    logic [lbsos_pkg::STEP_W-1:0] step_reg, step_next;

    logic [lbsos_pkg::MS_W-1:0]   el_inc;
    logic [lbsos_pkg::MS_W-1:0]   interval;
    logic [lbsos_pkg::STEP_W-1:0] step_cur;
    logic [lbsos_pkg::STEP_W-1:0] step_adv;

    always_comb begin
        el_inc   = (elapsed_reg == lbsos_pkg::ELAPSED_MAX) ? elapsed_reg
                                                           : elapsed_reg + 16'd1;
        interval = (mode_reg == lbsos_pkg::MODE_SLOW) ? cfg.slow_interval_ms
                                                      : cfg.fast_interval_ms;
        step_cur = (step_reg >= lbsos_pkg::SOS_STEPS) ? '0 : step_reg;
        step_adv = (step_cur == lbsos_pkg::SOS_WORD_STEP) ? '0 : step_cur + 5'd1;

        mode_next    = mode_reg;
        lit_next     = lit_reg;
        elapsed_next = elapsed_reg;
        step_next    = step_reg;

        if (cmd.tick) begin
            elapsed_next = el_inc;
            case (mode_reg)
                lbsos_pkg::MODE_ON: begin
                    lit_next = 1'b1;
                end
                lbsos_pkg::MODE_SLOW, lbsos_pkg::MODE_FAST: begin
                    if (el_inc >= interval) begin
                        lit_next     = ~lit_reg;
                        elapsed_next = '0;
                    end
                end
                lbsos_pkg::MODE_SOS: begin
                    step_next = step_cur;
                    if (el_inc >= lbsos_pkg::sos_duration(step_cur, cfg)) begin
                        step_next    = step_adv;
                        // lit on dot/dash steps, dark on gaps and the word gap
                        lit_next     = ~step_adv[0] && (step_adv != lbsos_pkg::SOS_WORD_STEP);
                        elapsed_next = '0;
                    end
                end
                default: begin
                    lit_next = 1'b0;
                end
            endcase
        end else if (cmd.set && cmd.mode != mode_reg) begin
            mode_next    = cmd.mode;
            elapsed_next = '0;
            step_next    = '0;
            lit_next     = (cmd.mode >= lbsos_pkg::MODE_ON) && (cmd.mode <= lbsos_pkg::MODE_SOS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= lbsos_pkg::MODE_OFF;
            lit_reg     <= 1'b0;
            elapsed_reg <= '0;
            step_reg    <= '0;
        end else begin
            mode_reg    <= mode_next;
            lit_reg     <= lit_next;
            elapsed_reg <= elapsed_next;
            step_reg    <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> design/lbsos_colour_scale.sv
`default_nettype none

module lbsos_colour_scale (
    input  wire [lbsos_pkg::CH_W-1:0]  channel,
    input  wire [lbsos_pkg::CH_W-1:0]  brightness,
    output logic [lbsos_pkg::CH_W-1:0] scaled
);

    logic [2*lbsos_pkg::CH_W-1:0] prod;
    logic [2*lbsos_pkg::CH_W:0]   sum;

    // x / 255 == (x + (x >> 8) + 1) >> 8 for any product of two 8-bit values
    always_comb begin
        prod   = channel * brightness;
        sum    = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        scaled = sum[15:8];
    end

endmodule

`default_nettype wire

>>> design/led_blink_sos_pattern_driver.sv
`default_nettype none

// channel   | ports                                  | beat
// ----------+----------------------------------------+---------------------------------
// input     | s_valid s_ready s_data                 | tick or set-mode item
// result    | m_valid m_ready m_data                 | lit flags, colour drive, status
// config    | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// One beat per cycle sustained while m_ready is high. An input register feeds
// the LED state update and colour scaling, which load the result register.
// Reset is synchronous and active low; it sets the registers to their defaults
// and all LEDs off. A stalled result holds the input register, which can still
// take one more beat.

module led_blink_sos_pattern_driver (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               s_valid,
    output logic                              s_ready,
    input  lbsos_pkg::in_item_t               s_data,

    output logic                              m_valid,
    input  wire                               m_ready,
    output lbsos_pkg::out_item_t              m_data,

    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [lbsos_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [lbsos_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lbsos_pkg::cfg_t      cfg_reg;
    lbsos_pkg::in_item_t  in_reg;
    logic                 in_valid_reg;
    lbsos_pkg::out_item_t out_reg;
    logic                 out_valid_reg;

    logic                 advance;
    logic                 bad_index;
    logic                 colour_lit;
    logic [lbsos_pkg::NUM_LEDS-1:0] lit_next;
    logic [lbsos_pkg::CH_W-1:0]     red_s, green_s, blue_s;
    lbsos_pkg::led_cmd_t  cmd [lbsos_pkg::NUM_LEDS];

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign bad_index = (in_reg.action == lbsos_pkg::ACT_SET)
                       && (int'(in_reg.led_index) >= lbsos_pkg::NUM_LEDS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_interval_ms <= 16'd1000;
            cfg_reg.fast_interval_ms <= 16'd200;
            cfg_reg.dot_ms           <= 16'd200;
            cfg_reg.dash_ms          <= 16'd600;
            cfg_reg.symbol_gap_ms    <= 16'd200;
            cfg_reg.word_gap_ms      <= 16'd600;
            cfg_reg.brightness       <= 8'd20;
            cfg_reg.base_colour      <= 24'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lbsos_pkg::REG_SLOW:       cfg_reg.slow_interval_ms <= cfg_data[15:0];
                lbsos_pkg::REG_FAST:       cfg_reg.fast_interval_ms <= cfg_data[15:0];
                lbsos_pkg::REG_DOT:        cfg_reg.dot_ms           <= cfg_data[15:0];
                lbsos_pkg::REG_DASH:       cfg_reg.dash_ms          <= cfg_data[15:0];
                lbsos_pkg::REG_SYM_GAP:    cfg_reg.symbol_gap_ms    <= cfg_data[15:0];
                lbsos_pkg::REG_WORD_GAP:   cfg_reg.word_gap_ms      <= cfg_data[15:0];
                lbsos_pkg::REG_BRIGHTNESS: cfg_reg.brightness       <= cfg_data[7:0];
                lbsos_pkg::REG_COLOUR:     cfg_reg.base_colour      <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    for (genvar i = 0; i < lbsos_pkg::NUM_LEDS; i++) begin : g_led
        always_comb begin
            cmd[i].tick = advance && (in_reg.action == lbsos_pkg::ACT_TICK);
            cmd[i].set  = advance && (in_reg.action == lbsos_pkg::ACT_SET)
                          && (int'(in_reg.led_index) == i);
            cmd[i].mode = in_reg.new_mode;
        end

        lbsos_led_unit u_led (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd[i]),
            .cfg      (cfg_reg),
            .lit_next (lit_next[i])
        );
    end

    // with a single LED there is no colour LED to report
    assign colour_lit = (lbsos_pkg::NUM_LEDS > 1) && lit_next[1 % lbsos_pkg::NUM_LEDS];

    lbsos_colour_scale u_red (
        .channel    (cfg_reg.base_colour[23:16]),
        .brightness (cfg_reg.brightness),
        .scaled     (red_s)
    );

    lbsos_colour_scale u_green (
        .channel    (cfg_reg.base_colour[15:8]),
        .brightness (cfg_reg.brightness),
        .scaled     (green_s)
    );

    lbsos_colour_scale u_blue (
        .channel    (cfg_reg.base_colour[7:0]),
        .brightness (cfg_reg.brightness),
        .scaled     (blue_s)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.plain_lit   <= lit_next[0];
            out_reg.colour_lit  <= colour_lit;
            out_reg.drive_red   <= colour_lit ? red_s   : '0;
            out_reg.drive_green <= colour_lit ? green_s : '0;
            out_reg.drive_blue  <= colour_lit ? blue_s  : '0;
            out_reg.status      <= bad_index ? lbsos_pkg::STATUS_BAD_IDX
                                             : lbsos_pkg::STATUS_OK;
        end
    end

endmodule

`default_nettype wire

>>> dv/led_blink_sos_pattern_driver_tb.sv
`timescale 1ns / 100ps

module led_blink_sos_pattern_driver_tb;

    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int LONG_TICKS  = 300;

    localparam logic [lbsos_pkg::IDX_W-1:0] IDX_PLAIN  = 2'd0;
    localparam logic [lbsos_pkg::IDX_W-1:0] IDX_COLOUR = 2'd1;
    localparam logic [lbsos_pkg::IDX_W-1:0] IDX_BAD_LO = 2'd2;
    localparam logic [lbsos_pkg::IDX_W-1:0] IDX_BAD_HI = 2'd3;

    // unused mode codes, all behave as off
    localparam logic [lbsos_pkg::MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [lbsos_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [lbsos_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    lbsos_pkg::in_item_t              s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    lbsos_pkg::out_item_t             m_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [lbsos_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lbsos_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow copy of the block's registers and per-LED state
    lbsos_pkg::cfg_t              shadow_cfg;
    logic [lbsos_pkg::MODE_W-1:0] led_mode_q [lbsos_pkg::NUM_LEDS];
    logic                         led_lit_q  [lbsos_pkg::NUM_LEDS];
    logic [lbsos_pkg::MS_W-1:0]   led_ms_q   [lbsos_pkg::NUM_LEDS];
    logic [lbsos_pkg::STEP_W-1:0] led_step_q [lbsos_pkg::NUM_LEDS];

    lbsos_pkg::out_item_t drive_q [$];
    lbsos_pkg::out_item_t want;

    int errors = 0;
    int n_in   = 0;
    int n_out  = 0;
    int n_cfg  = 0;
    int stall_cycles = 0;
    int in_gap_pct   = 0;
    int out_gap_pct  = 0;
    bit quiet   = 1'b0;
    bit hold_rx = 1'b0;

    led_blink_sos_pattern_driver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void reset_leds();
        shadow_cfg.slow_interval_ms = 16'd1000;
        shadow_cfg.fast_interval_ms = 16'd200;
        shadow_cfg.dot_ms           = 16'd200;
        shadow_cfg.dash_ms          = 16'd600;
        shadow_cfg.symbol_gap_ms    = 16'd200;
        shadow_cfg.word_gap_ms      = 16'd600;
        shadow_cfg.brightness       = 8'd20;
        shadow_cfg.base_colour      = '0;
        for (int i = 0; i < lbsos_pkg::NUM_LEDS; i++) begin
            led_mode_q[i] = lbsos_pkg::MODE_OFF;
            led_lit_q[i]  = 1'b0;
            led_ms_q[i]   = '0;
            led_step_q[i] = '0;
        end
    endfunction

    function automatic void note_reg_write(logic [lbsos_pkg::CFG_IDX_W-1:0] idx,
                                           logic [lbsos_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lbsos_pkg::REG_SLOW:
                shadow_cfg.slow_interval_ms = data[lbsos_pkg::MS_W-1:0];
            lbsos_pkg::REG_FAST:
                shadow_cfg.fast_interval_ms = data[lbsos_pkg::MS_W-1:0];
            lbsos_pkg::REG_DOT:
                shadow_cfg.dot_ms           = data[lbsos_pkg::MS_W-1:0];
            lbsos_pkg::REG_DASH:
                shadow_cfg.dash_ms          = data[lbsos_pkg::MS_W-1:0];
            lbsos_pkg::REG_SYM_GAP:
                shadow_cfg.symbol_gap_ms    = data[lbsos_pkg::MS_W-1:0];
            lbsos_pkg::REG_WORD_GAP:
                shadow_cfg.word_gap_ms      = data[lbsos_pkg::MS_W-1:0];
            lbsos_pkg::REG_BRIGHTNESS:
                shadow_cfg.brightness       = data[lbsos_pkg::CH_W-1:0];
            lbsos_pkg::REG_COLOUR:
                shadow_cfg.base_colour      = data[lbsos_pkg::COLOUR_W-1:0];
            default: ;
        endcase
    endfunction

    // length of one SOS step: mark on even steps, gap on odd, word gap last
    function automatic logic [lbsos_pkg::MS_W-1:0] sos_step_ms(
        logic [lbsos_pkg::STEP_W-1:0] s);
        if (s == lbsos_pkg::SOS_WORD_STEP) return shadow_cfg.word_gap_ms;
        if (s[0]) return shadow_cfg.symbol_gap_ms;
        if (s >= lbsos_pkg::SOS_DASH_FIRST && s <= lbsos_pkg::SOS_DASH_LAST)
            return shadow_cfg.dash_ms;
        return shadow_cfg.dot_ms;
    endfunction

    function automatic logic [lbsos_pkg::CH_W-1:0] scale_channel(
        logic [lbsos_pkg::CH_W-1:0] ch);
        logic [31:0] prod;
        prod = ch * shadow_cfg.brightness;
        prod = prod / 32'd255;
        return prod[lbsos_pkg::CH_W-1:0];
    endfunction

    function automatic void tick_led(int i);
        logic [lbsos_pkg::MS_W-1:0]   iv;
        logic [lbsos_pkg::STEP_W-1:0] s;
        if (led_ms_q[i] != lbsos_pkg::ELAPSED_MAX) led_ms_q[i] = led_ms_q[i] + 1'b1;
        case (led_mode_q[i])
            lbsos_pkg::MODE_ON: led_lit_q[i] = 1'b1;
            lbsos_pkg::MODE_SLOW, lbsos_pkg::MODE_FAST: begin
                iv = (led_mode_q[i] == lbsos_pkg::MODE_SLOW) ? shadow_cfg.slow_interval_ms
                                                             : shadow_cfg.fast_interval_ms;
                if (led_ms_q[i] >= iv) begin
                    led_lit_q[i] = !led_lit_q[i];
                    led_ms_q[i]  = '0;
                end
            end
            lbsos_pkg::MODE_SOS: begin
                s = (led_step_q[i] >= lbsos_pkg::SOS_STEPS) ? '0 : led_step_q[i];
                if (led_ms_q[i] >= sos_step_ms(s)) begin
                    s = (s == lbsos_pkg::SOS_WORD_STEP) ? '0 : s + 1'b1;
                    led_lit_q[i] = !s[0] && (s != lbsos_pkg::SOS_WORD_STEP);
                    led_ms_q[i]  = '0;
                end
                led_step_q[i] = s;
            end
            default: led_lit_q[i] = 1'b0;
        endcase
    endfunction

    // apply one beat to the shadow state and return the drive it leads to
    function automatic lbsos_pkg::out_item_t advance_leds(lbsos_pkg::in_item_t it);
        lbsos_pkg::out_item_t r;
        logic                 clit;
        r = '0;
        r.status = lbsos_pkg::STATUS_OK;
        if (it.action == lbsos_pkg::ACT_TICK) begin
            for (int i = 0; i < lbsos_pkg::NUM_LEDS; i++) tick_led(i);
        end else if (it.led_index >= lbsos_pkg::NUM_LEDS) begin
            r.status = lbsos_pkg::STATUS_BAD_IDX;
        end else if (it.new_mode != led_mode_q[it.led_index]) begin
            led_mode_q[it.led_index] = it.new_mode;
            led_ms_q[it.led_index]   = '0;
            led_step_q[it.led_index] = '0;
            led_lit_q[it.led_index]  = (it.new_mode >= lbsos_pkg::MODE_ON)
                                       && (it.new_mode <= lbsos_pkg::MODE_SOS);
        end
        clit = (lbsos_pkg::NUM_LEDS > 1) ? led_lit_q[1 % lbsos_pkg::NUM_LEDS] : 1'b0;
        r.plain_lit   = led_lit_q[0];
        r.colour_lit  = clit;
        r.drive_red   = clit ? scale_channel(shadow_cfg.base_colour[2*lbsos_pkg::CH_W +:
                                                                    lbsos_pkg::CH_W]) : '0;
        r.drive_green = clit ? scale_channel(shadow_cfg.base_colour[lbsos_pkg::CH_W +:
                                                                    lbsos_pkg::CH_W]) : '0;
        r.drive_blue  = clit ? scale_channel(shadow_cfg.base_colour[0 +:
                                                                    lbsos_pkg::CH_W]) : '0;
        return r;
    endfunction

    function automatic lbsos_pkg::in_item_t tick_item();
        lbsos_pkg::in_item_t it;
        logic [31:0]         r;
        r = $urandom;
        it.action    = lbsos_pkg::ACT_TICK;
        it.led_index = r[lbsos_pkg::IDX_W-1:0];
        it.new_mode  = r[8 +: lbsos_pkg::MODE_W];
        return it;
    endfunction

    function automatic lbsos_pkg::in_item_t set_item(logic [lbsos_pkg::IDX_W-1:0] idx,
                                                     logic [lbsos_pkg::MODE_W-1:0] mode);
        lbsos_pkg::in_item_t it;
        it.action    = lbsos_pkg::ACT_SET;
        it.led_index = idx;
        it.new_mode  = mode;
        return it;
    endfunction

    // mostly ticks; mode writes lean toward the on, blink and SOS modes
    function automatic lbsos_pkg::in_item_t random_item();
        lbsos_pkg::in_item_t          it;
        logic [31:0]                  r;
        logic [lbsos_pkg::MODE_W-1:0] mode;
        if ($urandom_range(99) < 85) return tick_item();
        if ($urandom_range(9) < 7) r = $urandom_range(lbsos_pkg::MODE_SOS, lbsos_pkg::MODE_ON);
        else r = $urandom;
        mode = r[lbsos_pkg::MODE_W-1:0];
        if ($urandom_range(9) < 8) r = $urandom_range(IDX_COLOUR, IDX_PLAIN);
        else r = $urandom_range(IDX_BAD_HI, IDX_BAD_LO);
        it = set_item(r[lbsos_pkg::IDX_W-1:0], mode);
        return it;
    endfunction

    task automatic send_item(lbsos_pkg::in_item_t it);
        if (!quiet && $urandom_range(99) < in_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        drive_q.push_back(advance_leds(it));
        n_in++;
    endtask

    task automatic write_reg(logic [lbsos_pkg::CFG_IDX_W-1:0] idx,
                             logic [lbsos_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        note_reg_write(idx, data);
        n_cfg++;
        @(posedge aclk);
    endtask

    // junk in the unused upper data bits must be dropped
    task automatic write_durations(logic [lbsos_pkg::MS_W-1:0] slow,
                                   logic [lbsos_pkg::MS_W-1:0] fast,
                                   logic [lbsos_pkg::MS_W-1:0] dot,
                                   logic [lbsos_pkg::MS_W-1:0] dash,
                                   logic [lbsos_pkg::MS_W-1:0] sym,
                                   logic [lbsos_pkg::MS_W-1:0] word);
        logic [lbsos_pkg::MS_W-1:0]       d [6];
        logic [lbsos_pkg::CFG_DATA_W-1:0] raw;
        logic [31:0]                      r;
        d = '{slow, fast, dot, dash, sym, word};
        for (int k = 0; k < 6; k++) begin
            r = $urandom;
            raw = r[lbsos_pkg::CFG_DATA_W-1:0];
            raw[lbsos_pkg::MS_W-1:0] = d[k];
            write_reg(lbsos_pkg::REG_SLOW + k[lbsos_pkg::CFG_IDX_W-1:0], raw);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic load_phase_config(int p);
        logic [lbsos_pkg::MS_W-1:0]       d [6];
        logic [lbsos_pkg::CH_W-1:0]       bright;
        logic [lbsos_pkg::COLOUR_W-1:0]   colour;
        logic [lbsos_pkg::CFG_DATA_W-1:0] raw;
        logic [31:0]                      r;
        for (int k = 0; k < 6; k++) begin
            r = $urandom_range(12, 0);
            d[k] = r[lbsos_pkg::MS_W-1:0];
        end
        r = $urandom;
        bright = r[lbsos_pkg::CH_W-1:0];
        r = $urandom;
        colour = r[lbsos_pkg::COLOUR_W-1:0];
        case (p)
            1: begin
                for (int k = 0; k < 6; k++) d[k] = '0;
                bright = '1;
                colour = '1;
            end
            2: bright = '0;
            3: begin
                d[0] = lbsos_pkg::ELAPSED_MAX;
                r = $urandom;
                d[3] = r[lbsos_pkg::MS_W-1:0];
            end
            default: ;
        endcase
        write_durations(d[0], d[1], d[2], d[3], d[4], d[5]);
        r = $urandom;
        raw = r[lbsos_pkg::CFG_DATA_W-1:0];
        raw[lbsos_pkg::CH_W-1:0] = bright;
        write_reg(lbsos_pkg::REG_BRIGHTNESS, raw);
        write_reg(lbsos_pkg::REG_COLOUR, colour);
        r = $urandom;
        raw = r[lbsos_pkg::CFG_DATA_W-1:0];
        r = $urandom_range(8'hFF, lbsos_pkg::REG_COLOUR + 8'd1);
        write_reg(r[lbsos_pkg::CFG_IDX_W-1:0], raw);
    endtask

    task automatic test_directed_patterns();
        in_gap_pct  = 20;
        out_gap_pct = 10;
        write_durations(16'd3, 16'd0, 16'd1, 16'd2, 16'd1, 16'd0);
        write_reg(lbsos_pkg::REG_BRIGHTNESS, 24'h5A5AFF);
        write_reg(lbsos_pkg::REG_COLOUR, 24'hFF00A5);
        send_item(tick_item());
        send_item(set_item(IDX_BAD_LO, lbsos_pkg::MODE_SOS));
        send_item(set_item(IDX_BAD_HI, MODE_SPARE7));
        send_item(set_item(IDX_PLAIN, lbsos_pkg::MODE_ON));
        send_item(set_item(IDX_COLOUR, lbsos_pkg::MODE_ON));
        send_item(tick_item());
        send_item(set_item(IDX_COLOUR, lbsos_pkg::MODE_ON));   // same mode, no restart
        send_item(set_item(IDX_PLAIN, lbsos_pkg::MODE_FAST));  // zero interval: toggle each tick
        repeat (2) send_item(tick_item());
        send_item(set_item(IDX_PLAIN, lbsos_pkg::MODE_SLOW));
        repeat (3) send_item(tick_item());
        send_item(set_item(IDX_COLOUR, lbsos_pkg::MODE_SOS));
        repeat (4) send_item(tick_item());
        send_item(set_item(IDX_COLOUR, MODE_SPARE5));
        send_item(set_item(IDX_PLAIN, MODE_SPARE6));
        send_item(set_item(IDX_COLOUR, MODE_SPARE7));
        send_item(set_item(IDX_PLAIN, lbsos_pkg::MODE_OFF));
        send_item(tick_item());
        drain_results();
    endtask

    // largest interval and word gap: no toggle while the counter climbs
    task automatic test_long_interval();
        write_durations(lbsos_pkg::ELAPSED_MAX, 16'd0, 16'd0, 16'd0, 16'd0,
                        lbsos_pkg::ELAPSED_MAX);
        quiet = 1'b1;
        send_item(set_item(IDX_PLAIN, lbsos_pkg::MODE_SLOW));
        send_item(set_item(IDX_COLOUR, lbsos_pkg::MODE_SOS));
        repeat (LONG_TICKS) send_item(tick_item());
        quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_backpressure();
        load_phase_config(0);
        in_gap_pct  = 0;
        out_gap_pct = 0;
        hold_rx = 1'b1;
        repeat (50) send_item(random_item());
        while (hold_rx) @(posedge aclk);
        drain_results();
        repeat (30) send_item(random_item());
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            load_phase_config(p);
            quiet       = (p == PHASES - 1);
            in_gap_pct  = (p % 3) * 15;
            out_gap_pct = ((p + 1) % 3) * 6;
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        drain_results();
    endtask

    initial begin
        reset_leds();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_patterns();
        test_long_interval();
        test_backpressure();
        test_random_phases();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d input beats, %0d result beats and %0d register writes",
                 n_in, n_out, n_cfg);
        $display("over directed modes, full-range intervals, back-pressure and %0d phases",
                 PHASES);
        if (errors == 0 && drive_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side ready: random stalls, or one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
                hold_rx = 1'b0;
            end else if (!quiet && $urandom_range(99) < out_gap_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_out++;
            if (drive_q.size() == 0) begin
                $error("result beat with no expected drive pending");
                errors++;
            end else begin
                want = drive_q.pop_front();
                if (m_data.plain_lit !== want.plain_lit) begin
                    $error("plain_lit: expected %0d, got %0d", want.plain_lit, m_data.plain_lit);
                    errors++;
                end
                if (m_data.colour_lit !== want.colour_lit) begin
                    $error("colour_lit: expected %0d, got %0d", want.colour_lit,
                           m_data.colour_lit);
                    errors++;
                end
                if (m_data.drive_red !== want.drive_red) begin
                    $error("drive_red: expected %0d, got %0d", want.drive_red, m_data.drive_red);
                    errors++;
                end
                if (m_data.drive_green !== want.drive_green) begin
                    $error("drive_green: expected %0d, got %0d", want.drive_green,
                           m_data.drive_green);
                    errors++;
                end
                if (m_data.drive_blue !== want.drive_blue) begin
                    $error("drive_blue: expected %0d, got %0d", want.drive_blue,
                           m_data.drive_blue);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

>>> sim.f
design/lbsos_pkg.sv
design/lbsos_led_unit.sv
design/lbsos_colour_scale.sv
design/led_blink_sos_pattern_driver.sv
dv/led_blink_sos_pattern_driver_tb.sv
